/* rtl/core/audio_bandpass_decimator_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the audio band-pass decimator
// Shared concurrent assertion forms, clocked on a rising edge and disabled
// while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef AUDIO_BANDPASS_DECIMATOR_MACROS_SVH
`define AUDIO_BANDPASS_DECIMATOR_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define ABD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("abd assertion failed");

// The consequent holds in the cycle after the antecedent.
`define ABD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("abd assertion failed");

`endif

/* rtl/core/abd_pkg.sv */
// ----------------------------------------------------------------------------
// Audio band-pass decimator package
// Widths, register codes, reset values and the configuration struct.
// ----------------------------------------------------------------------------
package abd_pkg;

	localparam int SAMPLE_BITS = 24;
	localparam int MUL_BITS    = 4;
	localparam int IO_W        = 24;
	localparam int LEVEL_W     = 32;
	localparam int SHIFT_IN    = 31 - MUL_BITS - SAMPLE_BITS;
	localparam int DIFF_W      = LEVEL_W + 1;
	localparam int PROD_W      = DIFF_W + MUL_BITS + 1;
	localparam int SHIFT_W     = 5;
	localparam int RATE_W      = 21;
	localparam int PHASE_W     = RATE_W + 1;
	localparam int CFG_DATA_W  = RATE_W;
	localparam int CFG_IDX_W   = 3;

	typedef logic signed [IO_W-1:0] pcm_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FILTER_ENABLE = 3'd0,
		REG_HP_MUL        = 3'd1,
		REG_HP_SHIFT      = 3'd2,
		REG_LP_MUL        = 3'd3,
		REG_LP_SHIFT      = 3'd4,
		REG_RATE_STEP     = 3'd5,
		REG_RATE_LIMIT    = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic                  filter_enable;
		logic [MUL_BITS-1:0]   hp_mul;
		logic [SHIFT_W-1:0]    hp_shift;
		logic [MUL_BITS-1:0]   lp_mul;
		logic [SHIFT_W-1:0]    lp_shift;
		logic [RATE_W-1:0]     rate_step;
		logic [RATE_W-1:0]     rate_limit;
	} cfg_t;

	localparam logic                  FILTER_ENABLE_RST = 1'b1;
	localparam logic [MUL_BITS-1:0]   HP_MUL_RST        = MUL_BITS'(8);
	localparam logic [SHIFT_W-1:0]    HP_SHIFT_RST      = SHIFT_W'(17);
	localparam logic [MUL_BITS-1:0]   LP_MUL_RST        = MUL_BITS'(12);
	localparam logic [SHIFT_W-1:0]    LP_SHIFT_RST      = SHIFT_W'(7);
	localparam logic [RATE_W-1:0]     RATE_STEP_RST     = RATE_W'(96000);
	localparam logic [RATE_W-1:0]     RATE_LIMIT_RST    = RATE_W'(985248);

endpackage

/* rtl/core/abd_stream_if.sv */
// ----------------------------------------------------------------------------
// Audio band-pass decimator stream interfaces
// Valid/ready channels for input samples and for decimated result samples.
// ----------------------------------------------------------------------------
interface abd_in_if;
	logic           valid;
	logic           ready;
	abd_pkg::pcm_t  sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

interface abd_out_if;
	logic           valid;
	logic           ready;
	abd_pkg::pcm_t  sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink (input valid, input sample_out, output ready);
endinterface

/* rtl/core/abd_cfg.sv */
// ----------------------------------------------------------------------------
// Audio band-pass decimator configuration registers
// Decodes the write port into the filter and rate registers.
// ----------------------------------------------------------------------------
module abd_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [abd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [abd_pkg::CFG_DATA_W-1:0]   cfg_data,
	output abd_pkg::cfg_t                    cfg
);
	import abd_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.filter_enable <= FILTER_ENABLE_RST;
			cfg_q.hp_mul        <= HP_MUL_RST;
			cfg_q.hp_shift      <= HP_SHIFT_RST;
			cfg_q.lp_mul        <= LP_MUL_RST;
			cfg_q.lp_shift      <= LP_SHIFT_RST;
			cfg_q.rate_step     <= RATE_STEP_RST;
			cfg_q.rate_limit    <= RATE_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_FILTER_ENABLE: cfg_q.filter_enable <= cfg_data[0];
				REG_HP_MUL:        cfg_q.hp_mul        <= cfg_data[MUL_BITS-1:0];
				REG_HP_SHIFT:      cfg_q.hp_shift      <= cfg_data[SHIFT_W-1:0];
				REG_LP_MUL:        cfg_q.lp_mul        <= cfg_data[MUL_BITS-1:0];
				REG_LP_SHIFT:      cfg_q.lp_shift      <= cfg_data[SHIFT_W-1:0];
				REG_RATE_STEP:     cfg_q.rate_step     <= cfg_data[RATE_W-1:0];
				REG_RATE_LIMIT:    cfg_q.rate_limit    <= cfg_data[RATE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* rtl/core/abd_filter.sv */
// ----------------------------------------------------------------------------
// Audio band-pass decimator filter stage
// First-order high-pass and low-pass level pair with saturated output, or the raw sample when disabled.
// ----------------------------------------------------------------------------
module abd_filter (
	input  logic           clk,
	input  logic           arst_n,
	input  abd_pkg::cfg_t  cfg,
	input  logic           update,
	input  abd_pkg::pcm_t  sample,
	output abd_pkg::pcm_t  result
);
	import abd_pkg::*;

	localparam logic signed [DIFF_W-1:0] SAT_HI = $signed(DIFF_W'((1 << (SAMPLE_BITS-1)) - 1));
	localparam logic signed [DIFF_W-1:0] SAT_LO = ~SAT_HI;

	logic signed [LEVEL_W-1:0]     hp_q;
	logic signed [LEVEL_W-1:0]     lp_q;
	logic signed [SAMPLE_BITS-1:0] x;
	logic signed [DIFF_W-1:0]      x_scaled;
	logic signed [DIFF_W-1:0]      hp_diff;
	logic signed [DIFF_W-1:0]      lp_diff;
	logic signed [PROD_W-1:0]      hp_coef;
	logic signed [PROD_W-1:0]      lp_coef;
	logic signed [PROD_W-1:0]      hp_prod;
	logic signed [PROD_W-1:0]      lp_prod;
	logic signed [PROD_W-1:0]      hp_sum;
	logic signed [PROD_W-1:0]      lp_sum;
	logic signed [LEVEL_W-1:0]     hp_next;
	logic signed [LEVEL_W-1:0]     lp_next;
	logic signed [DIFF_W-1:0]      out_diff;
	logic signed [DIFF_W-1:0]      y_wide;
	logic signed [SAMPLE_BITS-1:0] y_sat;

	always_comb begin
		x        = sample[SAMPLE_BITS-1:0];
		x_scaled = $signed(DIFF_W'(x)) <<< SHIFT_IN;

		hp_diff = $signed(DIFF_W'(lp_q)) - $signed(DIFF_W'(hp_q));
		lp_diff = x_scaled - $signed(DIFF_W'(lp_q));

		hp_coef = $signed(PROD_W'(cfg.hp_mul));
		lp_coef = $signed(PROD_W'(cfg.lp_mul));
		hp_prod = $signed(PROD_W'(hp_diff)) * hp_coef;
		lp_prod = $signed(PROD_W'(lp_diff)) * lp_coef;

		hp_sum  = $signed(PROD_W'(hp_q)) + (hp_prod >>> cfg.hp_shift);
		lp_sum  = $signed(PROD_W'(lp_q)) + (lp_prod >>> cfg.lp_shift);
		hp_next = hp_sum[LEVEL_W-1:0];
		lp_next = lp_sum[LEVEL_W-1:0];

		out_diff = $signed(DIFF_W'(lp_next)) - $signed(DIFF_W'(hp_next));
		y_wide   = out_diff >>> SHIFT_IN;
		if (y_wide > SAT_HI) begin
			y_sat = SAT_HI[SAMPLE_BITS-1:0];
		end else if (y_wide < SAT_LO) begin
			y_sat = SAT_LO[SAMPLE_BITS-1:0];
		end else begin
			y_sat = y_wide[SAMPLE_BITS-1:0];
		end

		if (cfg.filter_enable) begin
			result = $signed(IO_W'(y_sat));
		end else begin
			result = $signed(IO_W'(x));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hp_q <= '0;
			lp_q <= '0;
		end else if (update && cfg.filter_enable) begin
			hp_q <= hp_next;
			lp_q <= lp_next;
		end
	end

endmodule

/* rtl/core/abd_phase.sv */
// ----------------------------------------------------------------------------
// Audio band-pass decimator phase accumulator
// Adds the step each item and flags an emit when the limit is reached.
// ----------------------------------------------------------------------------
module abd_phase (
	input  logic          clk,
	input  logic          arst_n,
	input  abd_pkg::cfg_t cfg,
	input  logic          advance,
	output logic          emit
);
	import abd_pkg::*;

	logic [PHASE_W-1:0] phase_q;
	logic [PHASE_W-1:0] phase_sum;
	logic [PHASE_W-1:0] limit_ext;
	logic [PHASE_W-1:0] phase_next;

	always_comb begin
		phase_sum  = phase_q + PHASE_W'(cfg.rate_step);
		limit_ext  = PHASE_W'(cfg.rate_limit);
		emit       = (phase_sum >= limit_ext);
		phase_next = emit ? (phase_sum - limit_ext) : phase_sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (advance) begin
			phase_q <= phase_next;
		end
	end

endmodule

/* rtl/core/audio_bandpass_decimator.sv */
// ----------------------------------------------------------------------------
// Audio band-pass decimator
// Data path: an item taken waits in the input register; its result, if it
// emits, is registered for the output. Throughput: one input item per cycle;
// an item that emits waits in the input register while the previous result is not yet taken.
// Reset clears the filter levels, the phase and the valid flags, and loads
// the register defaults.
// ----------------------------------------------------------------------------
module audio_bandpass_decimator (
	input  logic                           clk,
	input  logic                           arst_n,
	abd_in_if.sink                         in_ch,
	abd_out_if.source                      out_ch,
	input  logic                           cfg_we,
	input  logic [abd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [abd_pkg::CFG_DATA_W-1:0] cfg_data
);
	import abd_pkg::*;

	cfg_t    cfg;
	logic    valid_s1;
	pcm_t    sample_s1;
	logic    out_valid_q;
	pcm_t    out_sample_q;
	logic    emit;
	logic    advance;
	pcm_t    result;

	abd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	abd_filter u_filter (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.update (advance),
		.sample (sample_s1),
		.result (result)
	);

	abd_phase u_phase (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.advance (advance),
		.emit    (emit)
	);

	assign advance     = valid_s1 && (!emit || !out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			sample_s1 <= in_ch.sample_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_sample_q <= result;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.sample_out = out_sample_q;

endmodule

/* rtl/core/abd_checker.sv */
// ----------------------------------------------------------------------------
// Audio band-pass decimator port checker
// Watches the top-level channels for handshake and flow-control slips.
// ----------------------------------------------------------------------------
`include "audio_bandpass_decimator_macros.svh"

module abd_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_ready,
	input logic           out_valid,
	input logic           out_ready,
	input abd_pkg::pcm_t  out_sample
);
	import abd_pkg::*;

	// A result that is not taken stays offered.
	`ABD_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	// A result that is not taken keeps its value.
	`ABD_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(out_sample))
	// The input side stalls only while a result is held back by the sink.
	`ABD_ASSERT_NOW(a_stall_cause, clk, arst_n, !in_ready, out_valid && !out_ready)
	// A new result appears only after the pipeline has moved.
	`ABD_ASSERT_NOW(a_rise_moved, clk, arst_n, $rose(out_valid), $past(in_ready))

endmodule

bind audio_bandpass_decimator abd_checker u_abd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.out_sample (out_ch.sample_out)
);
